>>> rtl/core/fnd_pkg.sv
// ----------------------------------------------------------------------------
// fnd_pkg
// Shared types, codes and helpers for the first-nonzero depth map.
// ----------------------------------------------------------------------------
package fnd_pkg;

    // Fixed limits of the volume geometry
    localparam int MAX_POINTS_DEFAULT = 65536;
    localparam int MAX_SLICES         = 4096;
    localparam int AXIS_MAX           = 256;

    // Field widths
    localparam int DEPTH_W = 13;
    localparam int COUNT_W = 17;
    localparam int CFG_W   = 13;
    localparam int PLANE_W = 16;

    typedef logic signed [DEPTH_W-1:0] fnd_depth_t;
    typedef logic [COUNT_W-1:0]        fnd_count_t;

    // Map entry for a point with no depth yet
    localparam fnd_depth_t DEPTH_UNFOUND = -13'sd1;

    // Input opcodes
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_STATUS  = 2'd3
    } fnd_op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PLANE_WIDTH  = 2'd0,
        REG_PLANE_HEIGHT = 2'd1,
        REG_SLICE_COUNT  = 2'd2,
        REG_NONE         = 2'd3
    } fnd_reg_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } fnd_state_t;

    // Effective volume sizes after clamping
    typedef struct packed {
        logic [COUNT_W-1:0] points;
        logic [DEPTH_W-1:0] slices;
    } fnd_size_t;

    // Address bits for a map of n entries
    function automatic int fnd_addr_bits(input int n);
        fnd_addr_bits = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> rtl/core/fnd_if.sv
// ----------------------------------------------------------------------------
// fnd_if
// Valid/ready channels carrying request and result beats of the depth map.
// ----------------------------------------------------------------------------
interface fnd_req_if;
    import fnd_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] sample_bits;
    logic [15:0] read_index;

    modport source (output valid, output opcode, output sample_bits,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input sample_bits,
                    input read_index, output ready);
endinterface

interface fnd_rsp_if;
    import fnd_pkg::*;

    logic       valid;
    logic       ready;
    fnd_depth_t depth_found;
    fnd_count_t found_count;
    logic       all_found;
    logic       volume_done;

    modport source (output valid, output depth_found, output found_count,
                    output all_found, output volume_done, input ready);
    modport sink   (input valid, input depth_found, input found_count,
                    input all_found, input volume_done, output ready);
endinterface

>>> rtl/core/first_nonzero_depth_map.sv
// ----------------------------------------------------------------------------
// first_nonzero_depth_map
// Records, per plane point, the first slice with a nonzero float sample.
// ----------------------------------------------------------------------------
// A request beat is accepted and its map entry read from the
// single-port-read map memory; once the output register is free, the read
// data returns, a newly found depth is written back and the result is loaded
// into the output register, and only then is the next beat accepted. After
// reset and after every restart beat all MAX_POINTS map entries (65536 by
// default) are swept to "unfound", one entry per cycle; no request is
// accepted during the sweep, while configuration writes are taken as normal.
// Results are registered; the next request is accepted while a result waits.
module first_nonzero_depth_map #(
    parameter int MAX_POINTS = fnd_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [fnd_pkg::CFG_W-1:0] cfg_data,
    fnd_req_if.sink                   req,
    fnd_rsp_if.source                 rsp
);
    import fnd_pkg::*;

    localparam int AW = fnd_addr_bits(MAX_POINTS);

    fnd_size_t     sizes;
    logic          ram_rd_en;
    logic [AW-1:0] ram_raddr;
    fnd_depth_t    ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    fnd_depth_t    ram_wdata;

    // Geometry registers
    fnd_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sizes     (sizes)
    );

    // Depth map memory
    fnd_map_ram #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_map (
        .clk   (clk),
        .rd_en (ram_rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    // Sequencer
    fnd_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sizes     (sizes),
        .req       (req),
        .rsp       (rsp),
        .ram_rd_en (ram_rd_en),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

`ifndef SYNTHESIS
    // No map write while a new beat may be taken: read and write never overlap
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !ram_we)
        else $error("map write while request channel ready");

    // An accepted beat blocks the channel for its write-back cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted during write-back");

    // Map reads are never issued back to back
    a_read_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |=> !ram_rd_en)
        else $error("back-to-back map reads");
`endif

endmodule

>>> rtl/core/fnd_cfg.sv
// ----------------------------------------------------------------------------
// fnd_cfg
// Geometry registers and the clamped point and slice totals.
// ----------------------------------------------------------------------------
module fnd_cfg #(
    parameter int MAX_POINTS = fnd_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [fnd_pkg::CFG_W-1:0] cfg_data,
    output fnd_pkg::fnd_size_t       sizes
);
    import fnd_pkg::*;

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [12:0] slices_reg;

    logic [8:0]         width_c;
    logic [8:0]         height_c;
    logic [12:0]        slices_c;
    logic [COUNT_W-1:0] product;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd1;
            height_reg <= 9'd1;
            slices_reg <= 13'd1;
        end
        else if (cfg_we)
        begin
            unique case (fnd_reg_t'(cfg_index))
                REG_PLANE_WIDTH:  width_reg  <= cfg_data[8:0];
                REG_PLANE_HEIGHT: height_reg <= cfg_data[8:0];
                REG_SLICE_COUNT:  slices_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp to legal ranges and form the totals
    always_comb
    begin
        width_c  = (width_reg == 9'd0) ? 9'd1 :
                   (width_reg > 9'(AXIS_MAX)) ? 9'(AXIS_MAX) : width_reg;
        height_c = (height_reg == 9'd0) ? 9'd1 :
                   (height_reg > 9'(AXIS_MAX)) ? 9'(AXIS_MAX) : height_reg;
        slices_c = (slices_reg == 13'd0) ? 13'd1 :
                   (slices_reg > 13'(MAX_SLICES)) ? 13'(MAX_SLICES) : slices_reg;
        product  = COUNT_W'(width_c) * COUNT_W'(height_c);

        sizes.points = (32'(product) > 32'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : product;
        sizes.slices = slices_c;
    end

endmodule

>>> rtl/core/fnd_map_ram.sv
// ----------------------------------------------------------------------------
// fnd_map_ram
// Depth map store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fnd_map_ram #(
    parameter int MAX_POINTS = fnd_pkg::MAX_POINTS_DEFAULT,
    parameter int AW         = fnd_pkg::fnd_addr_bits(MAX_POINTS)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       raddr,
    output fnd_pkg::fnd_depth_t rdata,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  fnd_pkg::fnd_depth_t wdata
);
    import fnd_pkg::*;

    fnd_depth_t mem [MAX_POINTS];
    fnd_depth_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fnd_ctrl.sv
// ----------------------------------------------------------------------------
// fnd_ctrl
// Sequencer: clearing sweep, map read-modify-write, counters, result register.
// ----------------------------------------------------------------------------
module fnd_ctrl #(
    parameter int MAX_POINTS = fnd_pkg::MAX_POINTS_DEFAULT,
    parameter int AW         = fnd_pkg::fnd_addr_bits(MAX_POINTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fnd_pkg::fnd_size_t  sizes,
    fnd_req_if.sink             req,
    fnd_rsp_if.source           rsp,
    output logic                ram_rd_en,
    output logic [AW-1:0]       ram_raddr,
    input  fnd_pkg::fnd_depth_t ram_rdata,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output fnd_pkg::fnd_depth_t ram_wdata
);
    import fnd_pkg::*;

    localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_POINTS - 1);

    fnd_state_t          state_reg, state_next;
    logic [AW-1:0]       sweep_addr_reg, sweep_addr_next;

    // Beat captured at acceptance
    fnd_op_t             op_reg;
    logic                nonzero_reg;
    logic                idx_ok_reg;

    // Volume state
    logic [PLANE_W-1:0]  plane_pos_reg, plane_pos_next;
    logic [DEPTH_W-1:0]  slice_pos_reg, slice_pos_next;
    fnd_count_t          found_reg, found_next;
    logic                finished_reg, finished_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    fnd_depth_t          depth_reg, depth_next;
    fnd_count_t          count_reg, count_next;
    logic                all_reg, all_next;
    logic                done_reg, done_next;

    logic                accept;
    logic                out_free;
    logic                exec_go;
    logic                map_we;
    logic [COUNT_W-1:0]  pos_ext;
    logic [COUNT_W-1:0]  pos_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign exec_go   = (state_reg == ST_EXEC) && out_free;

    // Map read issued with the accepted beat
    assign ram_rd_en = accept;
    assign ram_raddr = (fnd_op_t'(req.opcode) == OP_READ) ? AW'(req.read_index)
                                                          : AW'(plane_pos_reg);

    // Map write: sweep, or the sample update
    assign ram_we    = (state_reg == ST_SWEEP) || map_we;
    assign ram_waddr = (state_reg == ST_SWEEP) ? sweep_addr_reg : AW'(plane_pos_reg);
    assign ram_wdata = (state_reg == ST_SWEEP) ? DEPTH_UNFOUND : fnd_depth_t'(slice_pos_reg);

    // Step logic
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        plane_pos_next  = plane_pos_reg;
        slice_pos_next  = slice_pos_reg;
        found_next      = found_reg;
        finished_next   = finished_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        depth_next      = depth_reg;
        count_next      = count_reg;
        all_next        = all_reg;
        done_next       = done_reg;
        map_we          = 1'b0;
        pos_ext         = COUNT_W'(plane_pos_reg);
        pos_inc         = sizes.points;

        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_addr_reg == SWEEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                    depth_next = '0;

                    unique case (op_reg)
                        OP_SAMPLE:
                        begin
                            if (!finished_reg)
                            begin
                                if (slice_pos_reg >= sizes.slices || found_reg >= sizes.points)
                                begin
                                    finished_next = 1'b1;
                                end
                                else
                                begin
                                    if (pos_ext < sizes.points)
                                    begin
                                        if (ram_rdata == DEPTH_UNFOUND && nonzero_reg)
                                        begin
                                            map_we     = 1'b1;
                                            found_next = found_reg + 1'b1;
                                        end
                                        pos_inc = pos_ext + 1'b1;
                                    end
                                    // end of slice
                                    if (pos_inc >= sizes.points)
                                    begin
                                        plane_pos_next = '0;
                                        slice_pos_next = slice_pos_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        plane_pos_next = pos_inc[PLANE_W-1:0];
                                    end
                                    finished_next = (found_next >= sizes.points) ||
                                                    (slice_pos_next >= sizes.slices);
                                end
                            end
                        end

                        OP_READ:
                        begin
                            depth_next = idx_ok_reg ? ram_rdata : DEPTH_UNFOUND;
                        end

                        OP_RESTART:
                        begin
                            plane_pos_next  = '0;
                            slice_pos_next  = '0;
                            found_next      = '0;
                            finished_next   = 1'b0;
                            sweep_addr_next = '0;
                            state_next      = ST_SWEEP;
                        end

                        OP_STATUS: ;
                    endcase

                    out_valid_next = 1'b1;
                    count_next     = found_next;
                    all_next       = (found_next >= sizes.points);
                    done_next      = finished_next;
                end
            end

            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            plane_pos_reg  <= '0;
            slice_pos_reg  <= '0;
            found_reg      <= '0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            plane_pos_reg  <= plane_pos_next;
            slice_pos_reg  <= slice_pos_next;
            found_reg      <= found_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= fnd_op_t'(req.opcode);
            nonzero_reg <= |req.sample_bits[30:0];
            idx_ok_reg  <= (32'(req.read_index) < 32'(MAX_POINTS));
        end
        depth_reg <= depth_next;
        count_reg <= count_next;
        all_reg   <= all_next;
        done_reg  <= done_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.depth_found = depth_reg;
    assign rsp.found_count = count_reg;
    assign rsp.all_found   = all_reg;
    assign rsp.volume_done = done_reg;

endmodule

>>> test/fnd_tb_pkg.sv
// ----------------------------------------------------------------------------
// fnd_tb_pkg
// Depth map predictor and result scoreboard for the first-nonzero testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnd_tb_pkg;
    import fnd_pkg::*;

    // One result beat as the block should report it
    typedef struct {
        fnd_depth_t depth;
        fnd_count_t count;
        logic       all_found;
        logic       done;
    } depth_status_t;

    class depth_board;
        // Predicted block state
        fnd_depth_t          depth_map [MAX_POINTS_DEFAULT];
        logic [8:0]          width_reg;
        logic [8:0]          height_reg;
        logic [12:0]         slices_reg;
        int unsigned         plane_pos;
        int unsigned         slice_pos;
        int unsigned         found;
        bit                  finished;

        // Results still owed by the block, oldest first
        depth_status_t       expected_status [$];

        // Tallies for the summary
        int unsigned         mismatches;
        int unsigned         checked;
        int unsigned         samples;
        int unsigned         reads;
        int unsigned         restarts;

        function new();
            width_reg  = 9'd1;
            height_reg = 9'd1;
            slices_reg = 13'd1;
            mismatches = 0;
            checked    = 0;
            samples    = 0;
            reads      = 0;
            restarts   = 0;
            clear_volume();
        endfunction

        function int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned point_total();
            int unsigned n;
            n = clamp_range(width_reg, 1, AXIS_MAX) * clamp_range(height_reg, 1, AXIS_MAX);
            return (n > MAX_POINTS_DEFAULT) ? MAX_POINTS_DEFAULT : n;
        endfunction

        function int unsigned slice_total();
            int unsigned n;
            n = clamp_range(slices_reg, 1, 4096);
            return (n > MAX_SLICES) ? MAX_SLICES : n;
        endfunction

        function void clear_volume();
            foreach (depth_map[i])
                depth_map[i] = DEPTH_UNFOUND;
            plane_pos = 0;
            slice_pos = 0;
            found     = 0;
            finished  = 1'b0;
        endfunction

        // Register write; unused index is dropped
        function void set_reg(fnd_reg_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PLANE_WIDTH:  width_reg  = value[8:0];
                REG_PLANE_HEIGHT: height_reg = value[8:0];
                REG_SLICE_COUNT:  slices_reg = value[12:0];
                default: ;
            endcase
        endfunction

        // One sample beat: first nonzero per point, sizes taken live
        function void take_sample(logic [31:0] bits);
            int unsigned pts;
            int unsigned sls;
            pts = point_total();
            sls = slice_total();
            if (finished)
                return;
            if (slice_pos >= sls || found >= pts)
            begin
                finished = 1'b1;
                return;
            end
            if (plane_pos < pts)
            begin
                // sign bit ignored, so -0 counts as zero
                if (depth_map[plane_pos] == DEPTH_UNFOUND && bits[30:0] != 31'd0)
                begin
                    depth_map[plane_pos] = DEPTH_W'(slice_pos);
                    found++;
                end
                plane_pos++;
            end
            else
            begin
                // position left over from a larger plane closes the slice
                plane_pos = pts;
            end
            if (plane_pos >= pts)
            begin
                plane_pos = 0;
                slice_pos++;
            end
            if (found >= pts || slice_pos >= sls)
                finished = 1'b1;
        endfunction

        // Accepted request beat; returns 0 for a sample the block ignores
        function bit note_request(fnd_op_t op, logic [31:0] bits, logic [15:0] idx);
            depth_status_t st;
            bit            active;
            active   = 1'b1;
            st.depth = '0;
            case (op)
                OP_SAMPLE:
                begin
                    active = !finished;
                    if (active)
                        samples++;
                    take_sample(bits);
                end
                OP_READ:
                begin
                    reads++;
                    st.depth = (int'(idx) < MAX_POINTS_DEFAULT) ? depth_map[idx] : DEPTH_UNFOUND;
                end
                OP_RESTART:
                begin
                    restarts++;
                    clear_volume();
                end
                default: ;
            endcase
            st.count     = COUNT_W'(found);
            st.all_found = (found >= point_total());
            st.done      = finished;
            expected_status.push_back(st);
            return active;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_result(fnd_depth_t depth, fnd_count_t count, logic all_found,
                                   logic done);
            depth_status_t st;
            checked++;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing expected: %s %0d count %0d all %b done %b",
                             checked, "depth", depth, count, all_found, done);
                return;
            end
            st = expected_status.pop_front();
            if (depth !== st.depth || count !== st.count || all_found !== st.all_found
                || done !== st.done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected depth %0d count %0d all %b done %b, ",
                              "got depth %0d count %0d all %b done %b"},
                             checked, st.depth, st.count, st.all_found, st.done,
                             depth, count, all_found, done);
            end
        endfunction
    endclass

endpackage

>>> test/tb_first_nonzero_depth_map.sv
// ----------------------------------------------------------------------------
// tb_first_nonzero_depth_map
// Self-checking bench: directed corner beats, then random volumes of float
// samples with reads and restarts, every result compared with a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_nonzero_depth_map;
    import fnd_pkg::*;
    import fnd_tb_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fnd_req_if req ();
    fnd_rsp_if rsp ();

    first_nonzero_depth_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    depth_board  board;
    int unsigned gap_odds;
    int unsigned stall_odds;
    int unsigned active_beats;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Hard stop well past the slowest legal run (sweeps dominate)
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check accepted beats, stall ready in random bursts
    initial
    begin : rsp_drain
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                board.check_result(rsp.depth_found, rsp.found_count, rsp.all_found,
                                   rsp.volume_done);
            if (stall_left > 0)
                stall_left--;
            else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds)
                stall_left = $urandom_range(1, 9);
            rsp.ready <= (stall_left == 0);
        end
    end

    // One request beat, after an optional idle burst; returns at acceptance
    task automatic send_beat(input fnd_op_t op, input logic [31:0] bits,
                             input logic [15:0] idx);
        int gap;
        gap = 0;
        if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.opcode      <= op;
        req.sample_bits <= bits;
        req.read_index  <= idx;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        if (board.note_request(op, bits, idx))
            active_beats++;
    endtask

    // Stop requesting and let every owed result come back
    task automatic drain_results();
        req.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Back-to-back writes of all three sizes plus the unused index
    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] junk;
        junk      = CFG_W'($urandom());
        cfg_we    <= 1'b1;
        cfg_index <= REG_PLANE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        board.set_reg(REG_PLANE_WIDTH, w);
        cfg_index <= REG_PLANE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        board.set_reg(REG_PLANE_HEIGHT, h);
        cfg_index <= REG_SLICE_COUNT;
        cfg_data  <= s;
        @(posedge clk);
        board.set_reg(REG_SLICE_COUNT, s);
        cfg_index <= REG_NONE;
        cfg_data  <= junk;
        @(posedge clk);
        board.set_reg(REG_NONE, junk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus
    initial
    begin : stimulus
        int               phase;
        int unsigned      phase_start;
        int unsigned      target;
        int unsigned      zero_pct;
        int unsigned      pick;
        logic [31:0]      bits;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] s;

        board        = new();
        gap_odds     = 0;
        stall_odds   = 0;
        active_beats = 0;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_PLANE_WIDTH;
        cfg_data        <= '0;
        req.valid       <= 1'b0;
        req.opcode      <= OP_STATUS;
        req.sample_bits <= '0;
        req.read_index  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x2 plane, four slices, zero encodings and odd floats
        gap_odds   = 25;
        stall_odds = 25;
        set_geometry(13'd3, 13'd2, 13'd4);
        send_beat(OP_STATUS, 32'h0, 16'd0);
        send_beat(OP_READ, 32'h0, 16'd0);
        // slice 0: +0, -0, denormal, NaN, all ones, 1.0
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h8000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h0000_0001, 16'd0);
        send_beat(OP_SAMPLE, 32'h7FC0_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'hFFFF_FFFF, 16'd0);
        send_beat(OP_SAMPLE, 32'h3F80_0000, 16'd0);
        // slice 1: negative denormal finds point 0, found points stay put
        send_beat(OP_SAMPLE, 32'h8000_0001, 16'd0);
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h7F80_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h8000_0000, 16'd0);
        send_beat(OP_READ, 32'h0, 16'd0);
        send_beat(OP_READ, 32'hFFFF_FFFF, 16'd2);
        send_beat(OP_READ, 32'h0, 16'hFFFF);
        // slice 2: last point found, volume done, next sample ignored
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h4049_0FDB, 16'd0);
        send_beat(OP_SAMPLE, 32'hFFFF_FFFF, 16'd0);
        send_beat(OP_STATUS, 32'h0, 16'd0);
        send_beat(OP_RESTART, 32'h0, 16'd0);
        drain_results();

        // Directed: sizes shrunk mid-volume without a restart
        set_geometry(13'd4, 13'd1, 13'd3);
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        send_beat(OP_SAMPLE, 32'h8000_0000, 16'd0);
        drain_results();
        // upper data bits dropped; position now past the plane, slice closes
        set_geometry(13'h1E01, 13'h1E00, 13'd3);
        send_beat(OP_SAMPLE, 32'h0000_0000, 16'd0);
        drain_results();
        // zero sizes clamp to one; slice already past the end
        set_geometry(13'd0, 13'd0, 13'd0);
        send_beat(OP_SAMPLE, 32'h1234_5678, 16'd0);
        send_beat(OP_READ, 32'h0, 16'd1);
        send_beat(OP_RESTART, 32'h0, 16'd0);
        drain_results();

        // Random volumes, each opened by a restart
        for (phase = 0; phase < 10 && active_beats < 1050; phase++)
        begin
            target = 130;
            if (phase == 2)
            begin
                // full plane, slice count beyond the limit
                w      = 13'h01FF;
                h      = 13'd256;
                s      = 13'h1FFF;
                target = 60;
            end
            else if (phase == 5)
            begin
                w = 13'd256;
                h = 13'd1;
                s = 13'd4096;
            end
            else
            begin
                w = CFG_W'($urandom_range(1, 12));
                h = CFG_W'($urandom_range(1, 6));
                s = CFG_W'($urandom_range(2, 24));
            end
            case ($urandom_range(0, 2))
                0:       zero_pct = 50;
                1:       zero_pct = 80;
                default: zero_pct = 95;
            endcase
            // quiet handshakes towards the end of the run
            if (phase >= 8 || active_beats >= 880)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
                stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            end

            set_geometry(w, h, s);
            send_beat(OP_RESTART, $urandom(), 16'($urandom()));
            phase_start = active_beats;
            while (active_beats - phase_start < target && !board.finished)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                begin
                    bits = $urandom();
                    if ($urandom_range(0, 99) < zero_pct)
                        bits = bits & 32'h8000_0000;
                    send_beat(OP_SAMPLE, bits, 16'($urandom()));
                end
                else if (pick < 90)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_beat(OP_READ, $urandom(), 16'($urandom()));
                    else
                        send_beat(OP_READ, $urandom(),
                                  16'($urandom_range(0, board.point_total() - 1)));
                end
                else
                    send_beat(OP_STATUS, $urandom(), 16'($urandom()));
            end
            // a finished volume must shrug off further samples
            if (board.finished)
                send_beat(OP_SAMPLE, $urandom() | 32'h0000_0001, 16'($urandom()));
            send_beat(OP_READ, $urandom(), 16'($urandom()));
            drain_results();
        end

        // Tail: nothing owed, then an idle stretch for stray beats
        drain_results();
        repeat (8) @(posedge clk);

        $display("ran %0d live beats: %0d samples, %0d reads, %0d restarts, %0d random volumes",
                 active_beats, board.samples, board.reads, board.restarts, phase);
        $display("%0d results checked, %0d failures", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
